// ----- hdl/sdh_pkg.sv -----
package sdh_pkg;

    localparam int SUM_W           = 48;
    localparam int PADDR_W         = 5;
    localparam int NUM_BINS_DEF    = 256;
    localparam int NUM_SPECIES_DEF = 4;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_READ    = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef enum logic [2:0] {
        REG_AXIS   = 3'd0,
        REG_X_LOW  = 3'd1,
        REG_X_HIGH = 3'd2,
        REG_Y_LOW  = 3'd3,
        REG_Y_HIGH = 3'd4,
        REG_Z_LOW  = 3'd5,
        REG_Z_HIGH = 3'd6,
        REG_SCALE  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MUL,
        S_RD,
        S_MOD,
        S_CLR,
        S_PUSH
    } state_t;

    typedef struct packed {
        axis_t              axis_select;
        logic signed [31:0] x_low;
        logic signed [31:0] x_high;
        logic signed [31:0] y_low;
        logic signed [31:0] y_high;
        logic signed [31:0] z_low;
        logic signed [31:0] z_high;
        logic        [31:0] bin_scale;
    } cfg_t;

endpackage

// ----- hdl/sdh_if.sv -----
interface sdh_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [1:0]  species;
    logic        [31:0] weight;
    logic        [7:0]  bin_select;

    modport source (
        output valid, func, pos_x, pos_y, pos_z, species, weight, bin_select,
        input  ready
    );
    modport sink (
        input  valid, func, pos_x, pos_y, pos_z, species, weight, bin_select,
        output ready
    );
endinterface

interface sdh_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [7:0]                    bin_index;
    logic [sdh_pkg::SUM_W-1:0]     species_density;
    logic [sdh_pkg::SUM_W-1:0]     total_density;

    modport source (
        output valid, status, bin_index, species_density, total_density,
        input  ready
    );
    modport sink (
        input  valid, status, bin_index, species_density, total_density,
        output ready
    );
endinterface

// ----- hdl/sdh_ram.sv -----
module sdh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/sdh_regs.sv -----
module sdh_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdh_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sdh_pkg::cfg_t                cfg
);

    sdh_pkg::cfg_t     cfg_reg;
    sdh_pkg::cfg_t     cfg_next;
    sdh_pkg::reg_idx_t idx;

    assign idx    = sdh_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                sdh_pkg::REG_AXIS:   cfg_next.axis_select = sdh_pkg::axis_t'(pwdata[1:0]);
                sdh_pkg::REG_X_LOW:  cfg_next.x_low       = pwdata;
                sdh_pkg::REG_X_HIGH: cfg_next.x_high      = pwdata;
                sdh_pkg::REG_Y_LOW:  cfg_next.y_low       = pwdata;
                sdh_pkg::REG_Y_HIGH: cfg_next.y_high      = pwdata;
                sdh_pkg::REG_Z_LOW:  cfg_next.z_low       = pwdata;
                sdh_pkg::REG_Z_HIGH: cfg_next.z_high      = pwdata;
                sdh_pkg::REG_SCALE:  cfg_next.bin_scale   = pwdata;
                default:             cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sdh_pkg::REG_AXIS:   prdata = {30'd0, cfg_reg.axis_select};
            sdh_pkg::REG_X_LOW:  prdata = cfg_reg.x_low;
            sdh_pkg::REG_X_HIGH: prdata = cfg_reg.x_high;
            sdh_pkg::REG_Y_LOW:  prdata = cfg_reg.y_low;
            sdh_pkg::REG_Y_HIGH: prdata = cfg_reg.y_high;
            sdh_pkg::REG_Z_LOW:  prdata = cfg_reg.z_low;
            sdh_pkg::REG_Z_HIGH: prdata = cfg_reg.z_high;
            sdh_pkg::REG_SCALE:  prdata = cfg_reg.bin_scale;
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/species_density_histogram_top.sv -----
// Mass-density histogram along one axis, per species and in total. One
// transaction is in flight at a time: an add inside the box passes box check,
// 32x32 bin multiply, bin-row read, saturating update and write-back, and
// result hand-off; an add outside the box goes from the box check to the
// hand-off, a read skips the multiply, a no-op gives no result, and a clear
// zeroes the bin memory one row per cycle. The same clearing pass runs after
// reset, during which no item is accepted; configuration writes go through at
// all times. Each bin row holds all species sums and the total in one
// synchronous RAM word, so one read and one write serve each add.
module species_density_histogram_top #(
    parameter int NUM_BINS    = sdh_pkg::NUM_BINS_DEF,
    parameter int NUM_SPECIES = sdh_pkg::NUM_SPECIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdh_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    sdh_in_if.sink                      req,
    sdh_out_if.source                   rsp
);

    localparam int SW    = sdh_pkg::SUM_W;
    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int ROW_W = (NUM_SPECIES + 1) * SW;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [31:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + (SW+1)'(b);
        return s[SW] ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    sdh_pkg::cfg_t   cfg;
    sdh_pkg::state_t state_reg, state_next;

    sdh_pkg::func_t     func_reg, func_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [1:0]         sp_reg, sp_next;
    logic [31:0]        weight_reg, weight_next;
    logic [7:0]         sel_reg, sel_next;
    logic [31:0]        diff_reg, diff_next;
    logic [31:0]        prod_reg, prod_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [BIN_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               init_reg, init_next;

    sdh_pkg::status_t res_st_reg, res_st_next;
    logic [7:0]       res_bin_reg, res_bin_next;
    logic [SW-1:0]    res_sp_reg, res_sp_next, res_tot_reg, res_tot_next;

    logic             out_valid_reg, out_valid_next;
    sdh_pkg::status_t out_st_reg, out_st_next;
    logic [7:0]       out_bin_reg, out_bin_next;
    logic [SW-1:0]    out_sp_reg, out_sp_next, out_tot_reg, out_tot_next;

    logic               ram_we, ram_re;
    logic [BIN_W-1:0]   ram_waddr, ram_raddr;
    logic [ROW_W-1:0]   ram_wdata, ram_rdata, new_row;

    logic               in_box, sp_ok_add, sp_ok_rd, sel_ok, clr_last, out_free;
    logic [31:0]        diff_calc;
    logic [63:0]        prod_full;
    logic [BIN_W-1:0]   bin_clamped, sel_addr;
    logic [BIN_W+7:0]   bin_wide, sel_wide;
    logic [SW-1:0]      old_tot, new_tot, old_sp, new_sp;

    sdh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdh_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // box and bin arithmetic
    always_comb
    begin
        in_box = (px_reg >= cfg.x_low) && (px_reg <= cfg.x_high) &&
                 (py_reg >= cfg.y_low) && (py_reg <= cfg.y_high) &&
                 (pz_reg >= cfg.z_low) && (pz_reg <= cfg.z_high);
        sp_ok_add = 32'(sp_reg) < NUM_SPECIES;
        unique case (cfg.axis_select)
            sdh_pkg::AXIS_X:    diff_calc = px_reg - cfg.x_low;
            sdh_pkg::AXIS_Y:    diff_calc = py_reg - cfg.y_low;
            sdh_pkg::AXIS_Z:    diff_calc = pz_reg - cfg.z_low;
            sdh_pkg::AXIS_NONE: diff_calc = 32'd0;
            default:            diff_calc = 32'd0;
        endcase
        prod_full   = 64'(diff_reg) * 64'(cfg.bin_scale);
        bin_clamped = (prod_reg >= 32'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
                                                  : prod_reg[BIN_W-1:0];
        sel_wide    = {{BIN_W{1'b0}}, sel_reg};
        sel_ok      = sel_wide < (BIN_W+8)'(NUM_BINS);
        sel_addr    = sel_wide[BIN_W-1:0];
        bin_wide    = {8'd0, bin_reg};
        clr_last    = clr_cnt_reg == BIN_W'(NUM_BINS - 1);
        out_free    = !out_valid_reg || rsp.ready;
    end

    // bin-row update
    always_comb
    begin
        new_row  = ram_rdata;
        old_sp   = '0;
        sp_ok_rd = 1'b0;
        for (int i = 0; i < NUM_SPECIES; i++)
        begin
            if (32'(sp_reg) == i)
            begin
                old_sp   = ram_rdata[i*SW +: SW];
                sp_ok_rd = 1'b1;
                new_row[i*SW +: SW] = sat_add(ram_rdata[i*SW +: SW], weight_reg);
            end
        end
        new_sp  = sat_add(old_sp, weight_reg);
        old_tot = ram_rdata[NUM_SPECIES*SW +: SW];
        new_tot = sat_add(old_tot, weight_reg);
        new_row[NUM_SPECIES*SW +: SW] = new_tot;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdh_pkg::S_IDLE:
                if (req.valid)
                begin
                    state_next = sdh_pkg::S_CALC;
                end
            sdh_pkg::S_CALC:
                unique case (func_reg)
                    sdh_pkg::FUNC_ADD:
                        state_next = (in_box && sp_ok_add) ? sdh_pkg::S_MUL
                                                           : sdh_pkg::S_PUSH;
                    sdh_pkg::FUNC_READ:  state_next = sdh_pkg::S_RD;
                    sdh_pkg::FUNC_CLEAR: state_next = sdh_pkg::S_CLR;
                    sdh_pkg::FUNC_NOP:   state_next = sdh_pkg::S_IDLE;
                    default:             state_next = sdh_pkg::S_IDLE;
                endcase
            sdh_pkg::S_MUL: state_next = sdh_pkg::S_RD;
            sdh_pkg::S_RD:  state_next = sdh_pkg::S_MOD;
            sdh_pkg::S_MOD: state_next = sdh_pkg::S_PUSH;
            sdh_pkg::S_CLR:
                if (clr_last)
                begin
                    state_next = init_reg ? sdh_pkg::S_IDLE : sdh_pkg::S_PUSH;
                end
            sdh_pkg::S_PUSH:
                if (out_free)
                begin
                    state_next = sdh_pkg::S_IDLE;
                end
            default: state_next = sdh_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = bin_reg;
        ram_wdata = new_row;
        ram_raddr = bin_clamped;
        unique case (state_reg)
            sdh_pkg::S_IDLE: req.ready = 1'b1;
            sdh_pkg::S_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = (func_reg == sdh_pkg::FUNC_READ) ? sel_addr : bin_clamped;
            end
            sdh_pkg::S_MOD:  ram_we = (func_reg == sdh_pkg::FUNC_ADD);
            sdh_pkg::S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            sdh_pkg::S_CALC, sdh_pkg::S_MUL, sdh_pkg::S_PUSH: ;
            default: ;
        endcase
    end

    // datapath registers
    always_comb
    begin
        func_next    = func_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        sp_next      = sp_reg;
        weight_next  = weight_reg;
        sel_next     = sel_reg;
        diff_next    = diff_reg;
        prod_next    = prod_reg;
        bin_next     = bin_reg;
        clr_cnt_next = clr_cnt_reg;
        init_next    = init_reg;
        res_st_next  = res_st_reg;
        res_bin_next = res_bin_reg;
        res_sp_next  = res_sp_reg;
        res_tot_next = res_tot_reg;
        unique case (state_reg)
            sdh_pkg::S_IDLE:
                if (req.valid)
                begin
                    func_next   = sdh_pkg::func_t'(req.func);
                    px_next     = req.pos_x;
                    py_next     = req.pos_y;
                    pz_next     = req.pos_z;
                    sp_next     = req.species;
                    weight_next = req.weight;
                    sel_next    = req.bin_select;
                end
            sdh_pkg::S_CALC:
            begin
                diff_next    = diff_calc;
                clr_cnt_next = '0;
                res_st_next  = sdh_pkg::ST_OUTSIDE;
                res_bin_next = 8'd0;
                res_sp_next  = '0;
                res_tot_next = '0;
            end
            sdh_pkg::S_MUL: prod_next = prod_full[63:32];
            sdh_pkg::S_RD:
                bin_next = (func_reg == sdh_pkg::FUNC_READ) ? sel_addr : bin_clamped;
            sdh_pkg::S_MOD:
                if (func_reg == sdh_pkg::FUNC_ADD)
                begin
                    res_st_next  = sdh_pkg::ST_ADDED;
                    res_bin_next = bin_wide[7:0];
                    res_sp_next  = new_sp;
                    res_tot_next = new_tot;
                end
                else
                begin
                    res_st_next  = sdh_pkg::ST_READ;
                    res_bin_next = sel_reg;
                    res_sp_next  = (sel_ok && sp_ok_rd) ? old_sp : '0;
                    res_tot_next = sel_ok ? old_tot : '0;
                end
            sdh_pkg::S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + BIN_W'(1);
                res_st_next  = sdh_pkg::ST_CLEARED;
                res_bin_next = 8'd0;
                res_sp_next  = '0;
                res_tot_next = '0;
                if (clr_last)
                begin
                    init_next = 1'b0;
                end
            end
            sdh_pkg::S_PUSH: ;
            default: ;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_st_next    = out_st_reg;
        out_bin_next   = out_bin_reg;
        out_sp_next    = out_sp_reg;
        out_tot_next   = out_tot_reg;
        if (state_reg == sdh_pkg::S_PUSH && out_free)
        begin
            out_valid_next = 1'b1;
            out_st_next    = res_st_reg;
            out_bin_next   = res_bin_reg;
            out_sp_next    = res_sp_reg;
            out_tot_next   = res_tot_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_st_reg;
    assign rsp.bin_index       = out_bin_reg;
    assign rsp.species_density = out_sp_reg;
    assign rsp.total_density   = out_tot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdh_pkg::S_CLR;
            clr_cnt_reg   <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        sp_reg      <= sp_next;
        weight_reg  <= weight_next;
        sel_reg     <= sel_next;
        diff_reg    <= diff_next;
        prod_reg    <= prod_next;
        bin_reg     <= bin_next;
        res_st_reg  <= res_st_next;
        res_bin_reg <= res_bin_next;
        res_sp_reg  <= res_sp_next;
        res_tot_reg <= res_tot_next;
        out_st_reg  <= out_st_next;
        out_bin_reg <= out_bin_next;
        out_sp_reg  <= out_sp_next;
        out_tot_reg <= out_tot_next;
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT = 3_000_000;
    localparam int  NOP_DRAIN = 16;
    localparam logic [sdh_pkg::SUM_W-1:0] DENSITY_MAX = '1;

    typedef struct {
        sdh_pkg::func_t     func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [1:0]  species;
        logic        [31:0] weight;
        logic        [7:0]  bin_select;
    } atom_op_t;

    typedef struct {
        sdh_pkg::status_t          status;
        logic [7:0]                bin_index;
        logic [sdh_pkg::SUM_W-1:0] species_density;
        logic [sdh_pkg::SUM_W-1:0] total_density;
    } bin_report_t;

    typedef struct {
        bit                  is_cfg;
        sdh_pkg::reg_idx_t   reg_idx;
        logic [31:0]         reg_val;
        atom_op_t            op;
        bit                  typed;
        bin_report_t         want;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sdh_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    sdh_in_if  req_if ();
    sdh_out_if rsp_if ();

    species_density_histogram_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    // histogram mirror
    sdh_pkg::axis_t     cur_axis;
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic        [31:0] cur_scale;
    bit [sdh_pkg::SUM_W-1:0] species_sums [sdh_pkg::NUM_BINS_DEF*sdh_pkg::NUM_SPECIES_DEF];
    bit [sdh_pkg::SUM_W-1:0] total_sums [sdh_pkg::NUM_BINS_DEF];
    logic [7:0]         last_bin;

    bin_report_t reports_due [$];
    plan_row_t   plan [$];
    logic signed [31:0] rb_lo [3];
    logic signed [31:0] rb_hi [3];

    bit steady;
    int stall_left;
    int fails;
    int cycles;
    int n_added, n_outside, n_read, n_cleared, n_sent;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d transactions pending",
                     cycles, reports_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic plan_row_t op_row(sdh_pkg::func_t f, logic [31:0] x, y, z,
                                         logic [1:0] sp, logic [31:0] w, logic [7:0] sel);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.reg_idx = sdh_pkg::REG_AXIS;
        row.reg_val = '0;
        row.op.func = f;
        row.op.pos_x = x;
        row.op.pos_y = y;
        row.op.pos_z = z;
        row.op.species = sp;
        row.op.weight = w;
        row.op.bin_select = sel;
        row.typed = 1'b0;
        row.want.status = sdh_pkg::ST_ADDED;
        row.want.bin_index = '0;
        row.want.species_density = '0;
        row.want.total_density = '0;
        return row;
    endfunction

    function automatic plan_row_t typed_row(sdh_pkg::func_t f, logic [31:0] x, y, z,
                                            logic [1:0] sp, logic [31:0] w, logic [7:0] sel,
                                            sdh_pkg::status_t st, logic [7:0] bi,
                                            logic [sdh_pkg::SUM_W-1:0] sd, td);
        plan_row_t row;
        row = op_row(f, x, y, z, sp, w, sel);
        row.typed = 1'b1;
        row.want.status = st;
        row.want.bin_index = bi;
        row.want.species_density = sd;
        row.want.total_density = td;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(sdh_pkg::reg_idx_t idx, logic [31:0] v);
        plan_row_t row;
        row = op_row(sdh_pkg::FUNC_NOP, 0, 0, 0, 0, 0, 0);
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = v;
        return row;
    endfunction

    function automatic void draw_box();
        logic signed [31:0] t;
        for (int a = 0; a < 3; a++)
        begin
            rb_lo[a] = $urandom;
            rb_hi[a] = $urandom;
            if (rb_lo[a] > rb_hi[a])
            begin
                t = rb_lo[a];
                rb_lo[a] = rb_hi[a];
                rb_hi[a] = t;
            end
        end
    endfunction

    function automatic logic signed [31:0] pick_in(int a);
        longint span;
        longint off;
        int     c;
        if (box_lo[a] > box_hi[a])
            return $urandom;
        c = $urandom_range(9);
        if (c == 0)
            return box_lo[a];
        if (c == 1)
            return box_hi[a];
        span = longint'(box_hi[a]) - longint'(box_lo[a]);
        off = longint'($urandom) % (span + 1);
        return 32'(longint'(box_lo[a]) + off);
    endfunction

    task automatic histogram_update(input atom_op_t op, output bit produced,
                                    output bin_report_t rep);
        logic signed [31:0] p [3];
        bit          in_box;
        bit [31:0]   offset;
        bit [63:0]   prod;
        bit [7:0]    bin;
        bit [9:0]    k;
        bit [sdh_pkg::SUM_W:0] s;
        p[0] = op.pos_x;
        p[1] = op.pos_y;
        p[2] = op.pos_z;
        produced = 1'b1;
        rep.status = sdh_pkg::ST_OUTSIDE;
        rep.bin_index = '0;
        rep.species_density = '0;
        rep.total_density = '0;
        case (op.func)
            sdh_pkg::FUNC_ADD:
            begin
                in_box = 1'b1;
                for (int a = 0; a < 3; a++)
                    if (p[a] < box_lo[a] || p[a] > box_hi[a])
                        in_box = 1'b0;
                if (in_box)
                begin
                    // true difference is in [0, 2^32-1], so wraparound is exact
                    offset = (cur_axis == sdh_pkg::AXIS_NONE) ? 32'd0
                             : p[int'(cur_axis)] - box_lo[int'(cur_axis)];
                    prod = {32'd0, offset} * {32'd0, cur_scale};
                    bin = (prod[63:32] > 32'd255) ? 8'd255 : prod[39:32];
                    k = {bin, op.species};
                    s = {1'b0, species_sums[k]} + {17'd0, op.weight};
                    species_sums[k] = s[sdh_pkg::SUM_W] ? DENSITY_MAX
                                                        : s[sdh_pkg::SUM_W-1:0];
                    s = {1'b0, total_sums[bin]} + {17'd0, op.weight};
                    total_sums[bin] = s[sdh_pkg::SUM_W] ? DENSITY_MAX
                                                        : s[sdh_pkg::SUM_W-1:0];
                    rep.status = sdh_pkg::ST_ADDED;
                    rep.bin_index = bin;
                    rep.species_density = species_sums[k];
                    rep.total_density = total_sums[bin];
                    last_bin = bin;
                end
            end
            sdh_pkg::FUNC_READ:
            begin
                rep.status = sdh_pkg::ST_READ;
                rep.bin_index = op.bin_select;
                rep.species_density = species_sums[{op.bin_select, op.species}];
                rep.total_density = total_sums[op.bin_select];
            end
            sdh_pkg::FUNC_CLEAR:
            begin
                foreach (species_sums[i])
                    species_sums[i] = '0;
                foreach (total_sums[i])
                    total_sums[i] = '0;
                rep.status = sdh_pkg::ST_CLEARED;
            end
            default:
                produced = 1'b0;
        endcase
    endtask

    task automatic apb_write(input sdh_pkg::reg_idx_t idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == sdh_pkg::REG_AXIS) ? {30'd0, val[1:0]} : val;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
        begin
            $error("readback reg %s: expected %h, got %h", idx.name(), want, prdata);
            fails++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            sdh_pkg::REG_AXIS:   cur_axis = sdh_pkg::axis_t'(val[1:0]);
            sdh_pkg::REG_X_LOW:  box_lo[0] = val;
            sdh_pkg::REG_X_HIGH: box_hi[0] = val;
            sdh_pkg::REG_Y_LOW:  box_lo[1] = val;
            sdh_pkg::REG_Y_HIGH: box_hi[1] = val;
            sdh_pkg::REG_Z_LOW:  box_lo[2] = val;
            sdh_pkg::REG_Z_HIGH: box_hi[2] = val;
            sdh_pkg::REG_SCALE:  cur_scale = val;
            default: ;
        endcase
    endtask

    task automatic drain_reports();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    // a no-op can still be in flight once the last result is out
    task automatic settle();
        drain_reports();
        repeat (NOP_DRAIN) @(posedge clk);
    endtask

    task automatic set_box(input sdh_pkg::axis_t ax, input logic [31:0] xl, xh, yl, yh,
                           zl, zh, sc);
        settle();
        apb_write(sdh_pkg::REG_AXIS, 32'(ax));
        apb_write(sdh_pkg::REG_X_LOW, xl);
        apb_write(sdh_pkg::REG_X_HIGH, xh);
        apb_write(sdh_pkg::REG_Y_LOW, yl);
        apb_write(sdh_pkg::REG_Y_HIGH, yh);
        apb_write(sdh_pkg::REG_Z_LOW, zl);
        apb_write(sdh_pkg::REG_Z_HIGH, zh);
        apb_write(sdh_pkg::REG_SCALE, sc);
    endtask

    task automatic send_row(input plan_row_t row);
        int          gap;
        bit          produced;
        bin_report_t rep;
        gap = (!steady && $urandom_range(99) < 28) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= row.op.func;
        req_if.pos_x <= row.op.pos_x;
        req_if.pos_y <= row.op.pos_y;
        req_if.pos_z <= row.op.pos_z;
        req_if.species <= row.op.species;
        req_if.weight <= row.op.weight;
        req_if.bin_select <= row.op.bin_select;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        n_sent++;
        histogram_update(row.op, produced, rep);
        if (row.typed)
            rep = row.want;
        if (produced)
            reports_due.push_back(rep);
    endtask

    task automatic random_row(output plan_row_t row);
        int r;
        r = $urandom_range(99);
        row = op_row(sdh_pkg::FUNC_ADD, $urandom, $urandom, $urandom, 2'($urandom_range(3)),
                     ($urandom_range(99) < 30) ? $urandom : $urandom_range(0, 32'h0004_0000),
                     8'($urandom));
        if (r < 62 || r >= 95)
        begin
            row.op.pos_x = pick_in(0);
            row.op.pos_y = pick_in(1);
            row.op.pos_z = pick_in(2);
            if (r >= 95)
                row.op.weight = 32'hFFFF_FFFF;
        end
        else if (r < 72)
            ;
        else if (r < 88)
        begin
            row.op.func = sdh_pkg::FUNC_READ;
            if ($urandom_range(1) == 1)
                row.op.bin_select = last_bin;
        end
        else if (r < 91)
            row.op.func = sdh_pkg::FUNC_CLEAR;
        else
            row.op.func = sdh_pkg::FUNC_NOP;
    endtask

    task automatic run_phase(input int n, input bit pressure);
        plan_row_t row;
        for (int i = 0; i < n; i++)
        begin
            if (pressure && i == n / 4)
                stall_left = 300;
            if (pressure && i == n / 2)
                drain_reports();
            random_row(row);
            send_row(row);
        end
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= steady || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin : result_check
        bin_report_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected transaction: status %0d bin %0d", rsp_if.status,
                       rsp_if.bin_index);
                fails++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    fails++;
                end
                if (rsp_if.bin_index !== want.bin_index)
                begin
                    $error("bin_index: expected %0d, got %0d", want.bin_index,
                           rsp_if.bin_index);
                    fails++;
                end
                if (rsp_if.species_density !== want.species_density)
                begin
                    $error("species_density: expected %h, got %h", want.species_density,
                           rsp_if.species_density);
                    fails++;
                end
                if (rsp_if.total_density !== want.total_density)
                begin
                    $error("total_density: expected %h, got %h", want.total_density,
                           rsp_if.total_density);
                    fails++;
                end
                case (want.status)
                    sdh_pkg::ST_ADDED:   n_added++;
                    sdh_pkg::ST_OUTSIDE: n_outside++;
                    sdh_pkg::ST_READ:    n_read++;
                    default:             n_cleared++;
                endcase
            end
        end
    end

    initial
    begin
        logic [31:0] tiny_lo;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.func = sdh_pkg::FUNC_NOP;
        req_if.pos_x = '0;
        req_if.pos_y = '0;
        req_if.pos_z = '0;
        req_if.species = '0;
        req_if.weight = '0;
        req_if.bin_select = '0;
        cur_axis = sdh_pkg::AXIS_X;
        cur_scale = '0;
        last_bin = '0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        steady = 1'b0;
        stall_left = 0;

        // reset config: only the origin is inside, scale 0 puts it in bin 0
        plan.push_back(typed_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd0, 0, 8'd0,
                                 sdh_pkg::ST_READ, 8'd0, 0, 0));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 0, 0, 0, 2'd1, 32'h0001_0000, 8'd0,
                                 sdh_pkg::ST_ADDED, 8'd0, 48'h1_0000, 48'h1_0000));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 0, 0, 1, 2'd1, 32'h0001_0000, 8'd0,
                                 sdh_pkg::ST_OUTSIDE, 8'd0, 0, 0));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 0, 32'hFFFF_FFFF, 0, 2'd1,
                                 32'h0001_0000, 8'd0, sdh_pkg::ST_OUTSIDE, 8'd0, 0, 0));
        plan.push_back(op_row(sdh_pkg::FUNC_NOP, 32'h7FFF_FFFF, 0, 0, 2'd3, 32'hFFFF_FFFF,
                              8'd255));
        plan.push_back(typed_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd1, 0, 8'd0,
                                 sdh_pkg::ST_READ, 8'd0, 48'h1_0000, 48'h1_0000));
        plan.push_back(typed_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd3, 0, 8'd255,
                                 sdh_pkg::ST_READ, 8'd255, 0, 0));
        // x in [-8, 8], y and z unbounded, 16 bins per unit
        plan.push_back(cfg_row(sdh_pkg::REG_AXIS, 32'(sdh_pkg::AXIS_X)));
        plan.push_back(cfg_row(sdh_pkg::REG_X_LOW, 32'hFFF8_0000));
        plan.push_back(cfg_row(sdh_pkg::REG_X_HIGH, 32'h0008_0000));
        plan.push_back(cfg_row(sdh_pkg::REG_Y_LOW, 32'h8000_0000));
        plan.push_back(cfg_row(sdh_pkg::REG_Y_HIGH, 32'h7FFF_FFFF));
        plan.push_back(cfg_row(sdh_pkg::REG_Z_LOW, 32'h8000_0000));
        plan.push_back(cfg_row(sdh_pkg::REG_Z_HIGH, 32'h7FFF_FFFF));
        plan.push_back(cfg_row(sdh_pkg::REG_SCALE, 32'h0010_0000));
        plan.push_back(op_row(sdh_pkg::FUNC_ADD, 32'hFFF8_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                              2'd0, 32'hFFFF_FFFF, 8'd0));
        plan.push_back(op_row(sdh_pkg::FUNC_ADD, 32'h0008_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              2'd3, 32'hFFFF_FFFF, 8'd0));
        plan.push_back(op_row(sdh_pkg::FUNC_ADD, 0, 0, 0, 2'd2, 32'h0000_0001, 8'd0));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 32'h0008_0001, 0, 0, 2'd0, 32'h1, 8'd0,
                                 sdh_pkg::ST_OUTSIDE, 8'd0, 0, 0));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 32'hFFF7_FFFF, 0, 0, 2'd0, 32'h1, 8'd0,
                                 sdh_pkg::ST_OUTSIDE, 8'd0, 0, 0));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 32'h7FFF_FFFF, 0, 0, 2'd0, 32'h1, 8'd0,
                                 sdh_pkg::ST_OUTSIDE, 8'd0, 0, 0));
        plan.push_back(typed_row(sdh_pkg::FUNC_ADD, 32'h8000_0000, 0, 0, 2'd0, 32'h1, 8'd0,
                                 sdh_pkg::ST_OUTSIDE, 8'd0, 0, 0));
        plan.push_back(op_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd3, 0, 8'd255));
        plan.push_back(op_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd2, 0, 8'd128));
        plan.push_back(op_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd0, 0, 8'd0));
        plan.push_back(typed_row(sdh_pkg::FUNC_CLEAR, 0, 0, 0, 2'd0, 0, 8'd0,
                                 sdh_pkg::ST_CLEARED, 8'd0, 0, 0));
        plan.push_back(typed_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd3, 0, 8'd255,
                                 sdh_pkg::ST_READ, 8'd255, 0, 0));
        plan.push_back(cfg_row(sdh_pkg::REG_AXIS, 32'(sdh_pkg::AXIS_NONE)));
        plan.push_back(op_row(sdh_pkg::FUNC_ADD, 32'h0000_0005, 32'h1234_5678, 32'h8765_4321,
                              2'd1, 32'h1234_5678, 8'd77));
        plan.push_back(op_row(sdh_pkg::FUNC_NOP, 0, 0, 0, 2'd0, 0, 8'd0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                apb_write(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_row(plan[i]);
        end

        set_box(sdh_pkg::AXIS_Y, 32'hFF9C_0000, 32'h0064_0000, 32'hFFF6_0000, 32'h001E_0000,
                32'hFFCE_0000, 32'h0032_0000, 32'h0006_6666);
        run_phase(200, 1'b0);

        set_box(sdh_pkg::AXIS_Z, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100);
        steady = 1'b1;
        run_phase(120, 1'b0);
        steady = 1'b0;

        draw_box();
        set_box(sdh_pkg::AXIS_NONE, rb_lo[0], rb_hi[0], rb_lo[1], rb_hi[1], rb_lo[2],
                rb_hi[2], $urandom);
        run_phase(80, 1'b0);

        // x low above x high: nothing can land
        set_box(sdh_pkg::AXIS_X, 32'h0001_0000, 32'h0000_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        run_phase(40, 1'b0);

        tiny_lo = $urandom_range(0, 32'h7FFF_0000);
        set_box(sdh_pkg::AXIS_X, tiny_lo, tiny_lo + 32'h400, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        run_phase(120, 1'b1);

        draw_box();
        set_box(sdh_pkg::AXIS_Y, rb_lo[0], rb_hi[0], rb_lo[1], rb_hi[1], rb_lo[2], rb_hi[2],
                $urandom_range(0, 32'h0000_FFFF));
        run_phase(190, 1'b0);

        // origin-only box with zero scale: every add lands in bin 0
        set_box(sdh_pkg::AXIS_Z, 0, 0, 0, 0, 0, 0, 0);
        steady = 1'b1;
        repeat (4)
            send_row(op_row(sdh_pkg::FUNC_ADD, 0, 0, 0, 2'd2, 32'hFFFF_FFFF, 8'd0));
        repeat (3)
            send_row(op_row(sdh_pkg::FUNC_ADD, 0, 0, 0, 2'd1, 32'h0001_0000, 8'd0));
        send_row(op_row(sdh_pkg::FUNC_READ, 0, 0, 0, 2'd2, 0, 8'd0));
        send_row(op_row(sdh_pkg::FUNC_CLEAR, 0, 0, 0, 2'd0, 0, 8'd0));
        steady = 1'b0;

        drain_reports();
        repeat (30) @(posedge clk);

        $display("sent %0d transactions: %0d adds binned, %0d outside the box,",
                 n_sent, n_added, n_outside);
        $display("%0d bin reads, %0d clears, all axis modes, an empty box and a long stall",
                 n_read, n_cleared);
        if (fails == 0 && reports_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
